### hw/rtl/otrb_pkg.sv
// shared types and constants for the overwrite trace ring buffer
// depends on nothing; imported by otrb_store, the top level and the testbench
`default_nettype none

package otrb_pkg;

   // ring geometry
   localparam int RING_DEPTH = 1024;
   localparam int ADDR_W     = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int CNT_W      = $clog2(RING_DEPTH + 1);

   // fixed field widths
   localparam int OP_W    = 2;
   localparam int BYTE_W  = 8;
   localparam int IDX_W   = 10;
   localparam int COUNT_W = 11;
   localparam int TOTAL_W = 32;

   // width for comparing a logical index against the readable count
   localparam int CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;

   // operation codes; code 3 is a no-op
   typedef enum logic [OP_W-1:0] {
      OP_INIT  = 2'd0,
      OP_WRITE = 2'd1,
      OP_READ  = 2'd2
   } op_type;

   // one access to the byte store
   typedef struct packed {
      logic              wr_en;
      logic              rd_en;
      logic [ADDR_W-1:0] addr;
      logic [BYTE_W-1:0] wr_data;
   } store_req_type;

endpackage

`default_nettype wire

### hw/rtl/otrb_store.sv
// single-port byte store of the trace ring, registered read
// depends on otrb_pkg for geometry and the access struct
`default_nettype none

module otrb_store (
   input  wire                           clock,
   input  wire otrb_pkg::store_req_type  store_req,
   output logic [otrb_pkg::BYTE_W-1:0]   rd_data
);
   import otrb_pkg::*;

   logic [BYTE_W-1:0] mem [RING_DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   // at most one write and one read per cycle
   always_ff @(posedge clock) begin
      if (store_req.wr_en) begin
         mem[store_req.addr] <= store_req.wr_data;
      end
      if (store_req.rd_en) begin
         rd_data_ff <= mem[store_req.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### hw/rtl/overwrite_trace_ring_buffer_core.sv
// overwrite-oldest byte trace ring: session control, status and result port
// depends on otrb_pkg and otrb_store
// the result strobe comes in the cycle after the transaction is accepted
// throughput: one transaction per cycle; busy is never raised, since each
//   transaction makes at most one access to the single-port byte store
// reset: clears session count, write position, byte total and ready; the
//   byte store keeps whatever it holds and needs no clearing pass
`default_nettype none

module overwrite_trace_ring_buffer_core (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              start,
   output logic                             busy,
   input  wire  [otrb_pkg::OP_W-1:0]        req_op,
   input  wire  [otrb_pkg::BYTE_W-1:0]      req_write_byte,
   input  wire  [otrb_pkg::IDX_W-1:0]       req_read_index,
   output logic                             rsp_strobe,
   output logic [otrb_pkg::BYTE_W-1:0]      rsp_read_byte,
   output logic                             rsp_read_valid,
   output logic [otrb_pkg::COUNT_W-1:0]     rsp_stored_count,
   output logic                             rsp_wrapped_flag,
   output logic [otrb_pkg::TOTAL_W-1:0]     rsp_bytes_total,
   output logic [otrb_pkg::TOTAL_W-1:0]     rsp_session_number,
   output logic                             rsp_ready_res
);
   import otrb_pkg::*;

   // session state
   logic [ADDR_W-1:0]  write_pos_ff, write_pos_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [TOTAL_W-1:0] session_ff, session_in;
   logic               started_ff, started_in;

   // result control
   logic               strobe_ff, strobe_in;
   logic               rd_valid_ff, rd_valid_in;

   logic               accept;
   op_type             op;
   logic               wrapped;
   logic [CNT_W-1:0]   count;
   logic [CMP_W-1:0]   idx_ext;
   logic [ADDR_W:0]    slot_sum;
   logic [ADDR_W-1:0]  slot;
   logic               rd_hit;
   store_req_type      store_req;
   logic [BYTE_W-1:0]  store_rd_data;

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign op     = op_type'(req_op);

   // ring status from current state
   assign wrapped = (total_ff >= TOTAL_W'(RING_DEPTH));
   assign count   = wrapped ? CNT_W'(RING_DEPTH) : CNT_W'(write_pos_ff);

   // logical index to physical slot, oldest first
   assign idx_ext  = CMP_W'(req_read_index);
   assign rd_hit   = (idx_ext < CMP_W'(count));
   assign slot_sum = {1'b0, write_pos_ff} + {1'b0, idx_ext[ADDR_W-1:0]};
   always_comb begin
      if (!wrapped) begin
         slot = idx_ext[ADDR_W-1:0];
      end else if (slot_sum >= (ADDR_W+1)'(RING_DEPTH)) begin
         slot = ADDR_W'(slot_sum - (ADDR_W+1)'(RING_DEPTH));
      end else begin
         slot = slot_sum[ADDR_W-1:0];
      end
   end

   // next state and store access per transaction
   always_comb begin
      write_pos_in      = write_pos_ff;
      total_in          = total_ff;
      session_in        = session_ff;
      started_in        = started_ff;
      rd_valid_in       = 1'b0;
      strobe_in         = accept;
      store_req.wr_en   = 1'b0;
      store_req.rd_en   = 1'b0;
      store_req.addr    = slot;
      store_req.wr_data = req_write_byte;
      if (accept) begin
         unique case (op)
            OP_INIT: begin
               session_in   = session_ff + TOTAL_W'(1);
               write_pos_in = '0;
               total_in     = '0;
               started_in   = 1'b1;
            end
            OP_WRITE: begin
               if (started_ff) begin
                  store_req.wr_en = 1'b1;
                  store_req.addr  = write_pos_ff;
                  write_pos_in    = (write_pos_ff == ADDR_W'(RING_DEPTH - 1)) ?
                                    '0 : write_pos_ff + ADDR_W'(1);
                  if (total_ff != '1) begin
                     total_in = total_ff + TOTAL_W'(1);
                  end
               end
            end
            OP_READ: begin
               if (started_ff && rd_hit) begin
                  store_req.rd_en = 1'b1;
                  rd_valid_in     = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         write_pos_ff <= '0;
         total_ff     <= '0;
         session_ff   <= '0;
         started_ff   <= 1'b0;
         strobe_ff    <= 1'b0;
         rd_valid_ff  <= 1'b0;
      end else begin
         write_pos_ff <= write_pos_in;
         total_ff     <= total_in;
         session_ff   <= session_in;
         started_ff   <= started_in;
         strobe_ff    <= strobe_in;
         rd_valid_ff  <= rd_valid_in;
      end
   end

   otrb_store u_store (
      .clock     (clock),
      .store_req (store_req),
      .rd_data   (store_rd_data)
   );

   // result port: status reflects state after the transaction
   assign rsp_strobe         = strobe_ff;
   assign rsp_read_valid     = rd_valid_ff;
   assign rsp_read_byte      = rd_valid_ff ? store_rd_data : '0;
   assign rsp_stored_count   = COUNT_W'(count);
   assign rsp_wrapped_flag   = wrapped;
   assign rsp_bytes_total    = total_ff;
   assign rsp_session_number = session_ff;
   assign rsp_ready_res      = started_ff;

   // every accepted transaction gives exactly one result next cycle
   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> strobe_ff)
      else $error("accepted transaction produced no result");

   a_no_spurious_result: assert property (@(posedge clock) disable iff (reset)
      !accept |=> !strobe_ff)
      else $error("result strobe without a transaction");

   // a valid read only happens inside a session
   a_read_needs_session: assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> (strobe_ff && started_ff))
      else $error("valid read outside a session or without strobe");

   // before wrapping the write position tracks the byte total
   a_pos_tracks_total: assert property (@(posedge clock) disable iff (reset)
      !wrapped |-> (write_pos_ff == total_ff[ADDR_W-1:0]))
      else $error("write position and byte total disagree");

   // a write never lands in the same cycle as a read
   a_single_access: assert property (@(posedge clock) disable iff (reset)
      !(store_req.wr_en && store_req.rd_en))
      else $error("two byte store accesses in one cycle");

endmodule

`default_nettype wire

### tb/testbench.sv
// self-checking bench for overwrite_trace_ring_buffer_core: bursty command stimulus,
// in-class status predictor, field-by-field result compare
// depends on otrb_pkg and the ring buffer rtl
`timescale 1ns / 1ps

module testbench;
   import otrb_pkg::*;

   // unused opcode, treated as a no-op by the block
   localparam logic [OP_W-1:0] OP_NOP = 2'd3;
   localparam int ITEM_TARGET = 1750;
   localparam int IDLE_LIMIT  = 2000;

   // one result as seen on the rsp_ ports
   typedef struct {
      logic [BYTE_W-1:0]  read_byte;
      logic               read_valid;
      logic [COUNT_W-1:0] stored_count;
      logic               wrapped_flag;
      logic [TOTAL_W-1:0] bytes_total;
      logic [TOTAL_W-1:0] session_number;
      logic               ready_res;
   } ring_status_type;

   // ring state predictor plus queue of expected status words
   class ring_status_scoreboard;
      logic [BYTE_W-1:0]  ring_bytes [RING_DEPTH];
      logic [ADDR_W-1:0]  wr_slot;
      logic [TOTAL_W-1:0] total_bytes;
      logic [TOTAL_W-1:0] session_cnt;
      logic               session_open;
      ring_status_type    expected_status [$];
      int                 errors;

      function new();
         wr_slot      = '0;
         total_bytes  = '0;
         session_cnt  = '0;
         session_open = 1'b0;
         errors       = 0;
      endfunction

      function int pending();
         return expected_status.size();
      endfunction

      // exactly full counts as wrapped
      function logic ring_full();
         return total_bytes >= TOTAL_W'(RING_DEPTH);
      endfunction

      function logic [COUNT_W-1:0] readable();
         return ring_full() ? COUNT_W'(RING_DEPTH) : COUNT_W'(wr_slot);
      endfunction

      // apply one accepted transaction and queue the status it yields
      function void note_transaction(logic [OP_W-1:0] op, logic [BYTE_W-1:0] wr_byte,
                                     logic [IDX_W-1:0] rd_index);
         ring_status_type st;
         int unsigned     slot;
         st.read_byte  = '0;
         st.read_valid = 1'b0;
         case (op)
            OP_INIT: begin
               session_cnt  = session_cnt + TOTAL_W'(1);
               wr_slot      = '0;
               total_bytes  = '0;
               session_open = 1'b1;
            end
            OP_WRITE: begin
               if (session_open) begin
                  ring_bytes[wr_slot] = wr_byte;
                  wr_slot = (wr_slot == ADDR_W'(RING_DEPTH - 1)) ? '0 : wr_slot + ADDR_W'(1);
                  if (total_bytes != '1)
                     total_bytes = total_bytes + TOTAL_W'(1);
               end
            end
            OP_READ: begin
               if (session_open && (COUNT_W'(rd_index) < readable())) begin
                  // oldest byte sits at the write slot once wrapped
                  if (ring_full())
                     slot = (int'(wr_slot) + int'(rd_index)) % RING_DEPTH;
                  else
                     slot = int'(rd_index);
                  st.read_byte  = ring_bytes[slot];
                  st.read_valid = 1'b1;
               end
            end
            default: ;
         endcase
         st.stored_count   = readable();
         st.wrapped_flag   = ring_full();
         st.bytes_total    = total_bytes;
         st.session_number = session_cnt;
         st.ready_res      = session_open;
         expected_status.push_back(st);
      endfunction

      function void compare_field(string field, logic [TOTAL_W-1:0] want,
                                  logic [TOTAL_W-1:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         end
      endfunction

      // compare one result against the oldest expectation
      function void check_status(ring_status_type seen);
         ring_status_type want;
         if (expected_status.size() == 0) begin
            errors++;
            $display("%0t: result with no transaction pending, expected none, actual byte %0d",
                     $time, seen.read_byte);
            return;
         end
         want = expected_status.pop_front();
         compare_field("read_byte", TOTAL_W'(want.read_byte), TOTAL_W'(seen.read_byte));
         compare_field("read_valid", TOTAL_W'(want.read_valid), TOTAL_W'(seen.read_valid));
         compare_field("stored_count", TOTAL_W'(want.stored_count),
                       TOTAL_W'(seen.stored_count));
         compare_field("wrapped_flag", TOTAL_W'(want.wrapped_flag),
                       TOTAL_W'(seen.wrapped_flag));
         compare_field("bytes_total", want.bytes_total, seen.bytes_total);
         compare_field("session_number", want.session_number, seen.session_number);
         compare_field("ready_res", TOTAL_W'(want.ready_res), TOTAL_W'(seen.ready_res));
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [OP_W-1:0]     req_op = '0;
   logic [BYTE_W-1:0]   req_write_byte = '0;
   logic [IDX_W-1:0]    req_read_index = '0;
   logic                rsp_strobe;
   logic [BYTE_W-1:0]   rsp_read_byte;
   logic                rsp_read_valid;
   logic [COUNT_W-1:0]  rsp_stored_count;
   logic                rsp_wrapped_flag;
   logic [TOTAL_W-1:0]  rsp_bytes_total;
   logic [TOTAL_W-1:0]  rsp_session_number;
   logic                rsp_ready_res;

   ring_status_scoreboard sb;
   ring_status_type       seen_status;
   int                    idle_cycles = 0;
   int                    items_sent = 0;
   int                    burst_left = 0;
   int                    sess_writes = 0;

   overwrite_trace_ring_buffer_core dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_op             (req_op),
      .req_write_byte     (req_write_byte),
      .req_read_index     (req_read_index),
      .rsp_strobe         (rsp_strobe),
      .rsp_read_byte      (rsp_read_byte),
      .rsp_read_valid     (rsp_read_valid),
      .rsp_stored_count   (rsp_stored_count),
      .rsp_wrapped_flag   (rsp_wrapped_flag),
      .rsp_bytes_total    (rsp_bytes_total),
      .rsp_session_number (rsp_session_number),
      .rsp_ready_res      (rsp_ready_res)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // monitor: check results, record accepted transactions, watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) begin
            seen_status.read_byte      = rsp_read_byte;
            seen_status.read_valid     = rsp_read_valid;
            seen_status.stored_count   = rsp_stored_count;
            seen_status.wrapped_flag   = rsp_wrapped_flag;
            seen_status.bytes_total    = rsp_bytes_total;
            seen_status.session_number = rsp_session_number;
            seen_status.ready_res      = rsp_ready_res;
            sb.check_status(seen_status);
         end
         if (start && !busy)
            sb.note_transaction(req_op, req_write_byte, req_read_index);
         if (rsp_strobe || (start && !busy))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("** overwrite_trace_ring_buffer_core: FAILED **");
            $finish;
         end
      end
   end

   // one transaction; bursts of random length separated by random gaps
   task automatic issue(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] wr_byte,
                        input logic [IDX_W-1:0] rd_index);
      int gap;
      int pick;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 8);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         pick = $urandom_range(0, 9);
         if (pick < 5)
            burst_left = $urandom_range(1, 4);
         else if (pick < 9)
            burst_left = $urandom_range(5, 20);
         else
            burst_left = $urandom_range(50, 150);
      end
      start          <= 1'b1;
      req_op         <= op;
      req_write_byte <= wr_byte;
      req_read_index <= rd_index;
      @(posedge clock);
      while (busy) @(posedge clock);
      burst_left--;
      items_sent++;
      if (op == OP_INIT)
         sess_writes = 0;
      else if (op == OP_WRITE)
         sess_writes++;
   endtask

   // hold the sender off until every expected result has come back
   task automatic drain();
      start <= 1'b0;
      do @(negedge clock); while (sb.pending() != 0);
      @(posedge clock);
   endtask

   // logical read position: mostly inside the readable range, edges favored
   function automatic logic [IDX_W-1:0] pick_index();
      int readable_cnt;
      int pick;
      readable_cnt = (sess_writes >= RING_DEPTH) ? RING_DEPTH : sess_writes;
      pick = $urandom_range(0, 9);
      if (readable_cnt == 0 || pick < 2)
         return IDX_W'($urandom_range(0, (1 << IDX_W) - 1));
      else if (pick == 2)
         return '0;
      else if (pick == 3)
         return IDX_W'(readable_cnt - 1);
      return IDX_W'($urandom_range(0, readable_cnt - 1));
   endfunction

   // random operation mix; whatever is left over is a fresh init
   task automatic random_op(input int write_pct, input int read_pct, input int nop_pct);
      int pick;
      logic [BYTE_W-1:0] wr_byte;
      logic [IDX_W-1:0]  rd_index;
      pick     = $urandom_range(0, 99);
      wr_byte  = BYTE_W'($urandom_range(0, 255));
      rd_index = IDX_W'($urandom_range(0, (1 << IDX_W) - 1));
      if (pick < write_pct)
         issue(OP_WRITE, wr_byte, rd_index);
      else if (pick < write_pct + read_pct)
         issue(OP_READ, wr_byte, pick_index());
      else if (pick < write_pct + read_pct + nop_pct)
         issue(OP_NOP, wr_byte, rd_index);
      else
         issue(OP_INIT, wr_byte, rd_index);
   endtask

   initial begin
      int fill_target;
      bit full_probed;
      int sess_len;
      sb = new();
      full_probed = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // before init: writes, reads and the no-op all report an idle ring
      issue(OP_WRITE, 8'hFF, 10'h3FF);
      issue(OP_READ, 8'h00, 10'h000);
      issue(OP_NOP, 8'hFF, 10'h3FF);
      // first session: empty read, byte extremes, reads in and past range
      issue(OP_INIT, 8'h00, 10'h000);
      issue(OP_READ, 8'h00, 10'h000);
      issue(OP_WRITE, 8'h00, 10'h3FF);
      issue(OP_WRITE, 8'hFF, 10'h000);
      issue(OP_WRITE, 8'hA5, 10'h155);
      issue(OP_READ, 8'h00, 10'h000);
      issue(OP_READ, 8'h00, 10'h002);
      issue(OP_READ, 8'h00, 10'h003);
      issue(OP_READ, 8'hFF, 10'h3FF);
      issue(OP_NOP, 8'h00, 10'h000);
      // repeated init: old bytes stay in the store but are not readable
      issue(OP_INIT, 8'hFF, 10'h3FF);
      issue(OP_READ, 8'h00, 10'h000);
      issue(OP_WRITE, 8'h5A, 10'h2AA);
      issue(OP_READ, 8'h00, 10'h000);
      issue(OP_READ, 8'h00, 10'h001);
      drain();

      // long write-heavy session: fill, probe exactly full, then wrap further
      issue(OP_INIT, BYTE_W'($urandom_range(0, 255)), pick_index());
      fill_target = RING_DEPTH + $urandom_range(40, 200);
      while (sess_writes < fill_target) begin
         random_op(85, 13, 2);
         if (sess_writes == RING_DEPTH && !full_probed) begin
            full_probed = 1'b1;
            issue(OP_READ, 8'h00, '0);
            issue(OP_READ, 8'hFF, IDX_W'(RING_DEPTH - 1));
            issue(OP_READ, 8'h3C, pick_index());
         end
      end

      // short sessions with mixed traffic and occasional mid-session init
      while (items_sent < ITEM_TARGET) begin
         if ($urandom_range(0, 3) == 0)
            drain();
         issue(OP_INIT, BYTE_W'($urandom_range(0, 255)), pick_index());
         sess_len = $urandom_range(3, 60);
         repeat (sess_len) random_op(50, 38, 6);
      end

      drain();
      repeat (5) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("** overwrite_trace_ring_buffer_core: PASSED **");
      else
         $display("** overwrite_trace_ring_buffer_core: FAILED **");
      $finish;
   end

endmodule

### files.f
hw/rtl/otrb_pkg.sv
hw/rtl/otrb_store.sv
hw/rtl/overwrite_trace_ring_buffer_core.sv
tb/testbench.sv
